// File: rtl/core/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by the decoder, the result queue, the top level and the checker.
package jsu_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OFF_W       = 16;

    typedef logic [OFFSET_BITS-1:0] pos_t;
    localparam pos_t POS_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_STR      = 4'd1,
        PH_ESC      = 4'd2,
        PH_HEX_HI   = 4'd3,
        PH_WANT_BSL = 4'd4,
        PH_WANT_U   = 4'd5,
        PH_HEX_LO   = 4'd6,
        PH_UTF8     = 4'd7,
        PH_SILENT   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_DONE   = 3'd1,
        ST_UNTERM = 3'd2,
        ST_ESC    = 3'd3,
        ST_UTF8   = 3'd4
    } status_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // One group of results caused by a single input byte.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
        status_t         status;
        logic [OFF_W-1:0] offset;
    } group_t;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last_idx;
    } utf8_enc_t;

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
        return v;
    endfunction

    // Sequence length for a lead byte; zero when it cannot start one.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b >= 8'hC2 && b <= 8'hDF) n = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF) n = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4) n = 3'd4;
        return n;
    endfunction

    // Bytes of the current raw sequence already held.
    function automatic logic [2:0] held_of(input logic [7:0] lead, input logic [1:0] rem);
        logic [2:0] len;
        logic [2:0] h;
        len = lead_len(lead);
        h   = (len > {1'b0, rem}) ? 3'(len - {1'b0, rem}) : 3'd1;
        return h;
    endfunction

    function automatic utf8_enc_t utf8_encode(input logic [20:0] cp);
        utf8_enc_t e;
        e.data     = '0;
        e.last_idx = 2'd0;
        if (cp <= 21'h7F) begin
            e.data[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            e.data[0]  = {3'b110, cp[10:6]};
            e.data[1]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd1;
        end
        else if (cp < 21'h10000) begin
            e.data[0]  = {4'b1110, cp[15:12]};
            e.data[1]  = {2'b10, cp[11:6]};
            e.data[2]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd2;
        end
        else begin
            e.data[0]  = {5'b11110, cp[20:18]};
            e.data[1]  = {2'b10, cp[17:12]};
            e.data[2]  = {2'b10, cp[11:6]};
            e.data[3]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd3;
        end
        return e;
    endfunction

endpackage

// File: rtl/core/json_string_unescaper_core.sv
// Results of an accepted byte are registered in the result queue before they are offered.
// Throughput: one input byte per cycle while each byte yields at most one result and
// the receiver does not stall; a byte yielding k results holds the output for k beats,
// and a two-group queue lets input continue while a result waits. Reset (rst_n low, asynchronous) empties
// the queue and returns the decoder to awaiting an opening quote.
module json_string_unescaper_core
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] error_offset
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last_of_run
);

    logic             take;
    logic             grp_valid;
    group_t           grp;
    logic             full;
    logic [7:0]       out_byte;
    status_t          out_status;
    logic [OFF_W-1:0] out_offset;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .grp_valid (grp_valid),
        .grp       (grp)
    );

    jsu_group_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (grp_valid),
        .push_grp   (grp),
        .full       (full),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_status (out_status),
        .out_last   (m_tlast),
        .out_offset (out_offset)
    );

    assign m_tdata = {out_offset, out_byte};
    assign m_tuser = out_status;

endmodule

// File: rtl/core/jsu_decode.sv
// Byte decoder: holds the string parsing state and turns one accepted byte
// into a group of results in a single pass. Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       grp_valid,
    output group_t     grp
);

    phase_t      phase_reg, phase_step, phase_next;
    logic [23:0] hold_reg, hold_step, hold_next;
    logic [1:0]  rem_reg, rem_step, rem_next;
    logic [15:0] accum_reg, accum_step, accum_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_step, hex_cnt_next;
    logic [9:0]  high_reg, high_step, high_next;
    pos_t        pos_reg, pos_next;

    pos_t        cur;
    pos_t        nxt;
    logic [4:0]  hex;
    logic        hex_bad;
    logic [15:0] accum_new;
    logic        is_hi;
    logic        is_lo;
    logic [7:0]  lead;
    logic [2:0]  held;
    logic [2:0]  held_end;
    logic [2:0]  b_len;
    logic [7:0]  cont_lo;
    logic [7:0]  cont_hi;
    logic        cont_ok;
    logic [20:0] cp_sel;
    utf8_enc_t   enc;

    logic        err;
    status_t     est;
    pos_t        eoff;
    logic        res_valid;

    assign cur       = pos_reg;
    assign nxt       = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign hex       = hex_value(in_byte);
    assign hex_bad   = hex[4];
    assign accum_new = {accum_reg[11:0], hex[3:0]};
    assign is_hi     = (accum_new >= HI_SURR_MIN) && (accum_new <= HI_SURR_MAX);
    assign is_lo     = (accum_new >= LO_SURR_MIN) && (accum_new <= LO_SURR_MAX);
    assign lead      = hold_reg[23:16];
    assign held      = held_of(lead, rem_reg);
    assign held_end  = held_of(hold_step[23:16], rem_step);
    assign b_len     = lead_len(in_byte);

    // The first continuation byte has narrower limits for a few lead bytes.
    always_comb
    begin
        cont_lo = 8'h80;
        cont_hi = 8'hBF;
        if (held == 3'd1) begin
            case (lead)
                8'hE0:   cont_lo = 8'hA0;
                8'hED:   cont_hi = 8'h9F;
                8'hF0:   cont_lo = 8'h90;
                8'hF4:   cont_hi = 8'h8F;
                default: cont_lo = 8'h80;
            endcase
        end
    end

    assign cont_ok = (in_byte >= cont_lo) && (in_byte <= cont_hi);

    assign cp_sel = (phase_reg == PH_HEX_LO)
                  ? SUPP_BASE + {1'b0, high_reg, accum_new[9:0]}
                  : {5'b0, accum_new};
    assign enc    = utf8_encode(cp_sel);

    // Error detection for the byte in hand.
    always_comb
    begin
        err  = 1'b0;
        est  = ST_DATA;
        eoff = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte != CH_QUOTE) begin
                    err = 1'b1;
                    est = ST_UNTERM;
                end
            end
            PH_STR:
            begin
                if (in_byte < 8'h20) begin
                    err  = 1'b1;
                    est  = ST_UNTERM;
                    eoff = cur;
                end
                else if (in_byte >= 8'h80 && b_len == 3'd0) begin
                    err  = 1'b1;
                    est  = ST_UTF8;
                    eoff = cur;
                end
            end
            PH_ESC:
            begin
                case (in_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U:
                        err = 1'b0;
                    default:
                    begin
                        err  = 1'b1;
                        est  = ST_ESC;
                        eoff = nxt;
                    end
                endcase
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                if (hex_bad) begin
                    err  = 1'b1;
                    est  = ST_ESC;
                    eoff = cur;
                end
                else if (hex_cnt_reg == 2'd3) begin
                    if ((phase_reg == PH_HEX_HI && is_lo) ||
                        (phase_reg == PH_HEX_LO && !is_lo)) begin
                        err  = 1'b1;
                        est  = ST_ESC;
                        eoff = nxt;
                    end
                end
            end
            PH_WANT_BSL:
            begin
                if (in_byte != CH_BSL) begin
                    err  = 1'b1;
                    est  = ST_ESC;
                    eoff = cur;
                end
            end
            PH_WANT_U:
            begin
                if (in_byte != CH_U) begin
                    err  = 1'b1;
                    est  = ST_ESC;
                    eoff = cur;
                end
            end
            PH_UTF8:
            begin
                if (!cont_ok) begin
                    err  = 1'b1;
                    est  = ST_UTF8;
                    eoff = (cur >= pos_t'(held)) ? cur - pos_t'(held) : '0;
                end
            end
            default:
                err = 1'b0;
        endcase
    end

    // Next state before the end-of-buffer reset is applied.
    always_comb
    begin
        phase_step   = phase_reg;
        hold_step    = hold_reg;
        rem_step     = rem_reg;
        accum_step   = accum_reg;
        hex_cnt_step = hex_cnt_reg;
        high_step    = high_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte == CH_QUOTE) phase_step = PH_STR;
            end
            PH_STR:
            begin
                if (in_byte == CH_QUOTE) begin
                    phase_step = PH_SILENT;
                end
                else if (in_byte == CH_BSL) begin
                    phase_step = PH_ESC;
                end
                else if (in_byte >= 8'h80 && b_len != 3'd0) begin
                    hold_step  = {in_byte, 16'h0000};
                    rem_step   = 2'(b_len - 3'd1);
                    phase_step = PH_UTF8;
                end
            end
            PH_ESC:
            begin
                phase_step = PH_STR;
                if (in_byte == CH_U) begin
                    phase_step   = PH_HEX_HI;
                    hex_cnt_step = 2'd0;
                    accum_step   = 16'h0000;
                end
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                if (!hex_bad) begin
                    accum_step = accum_new;
                    if (hex_cnt_reg != 2'd3) begin
                        hex_cnt_step = hex_cnt_reg + 2'd1;
                    end
                    else begin
                        hex_cnt_step = 2'd0;
                        if (phase_reg == PH_HEX_HI) begin
                            if (is_hi) begin
                                high_step  = accum_new[9:0];
                                phase_step = PH_WANT_BSL;
                            end
                            else if (!is_lo) begin
                                phase_step = PH_STR;
                            end
                        end
                        else if (is_lo) begin
                            phase_step = PH_STR;
                        end
                    end
                end
            end
            PH_WANT_BSL:
            begin
                if (in_byte == CH_BSL) phase_step = PH_WANT_U;
            end
            PH_WANT_U:
            begin
                if (in_byte == CH_U) begin
                    phase_step   = PH_HEX_LO;
                    hex_cnt_step = 2'd0;
                    accum_step   = 16'h0000;
                end
            end
            PH_UTF8:
            begin
                if (cont_ok) begin
                    if (rem_reg <= 2'd1) begin
                        rem_step   = 2'd0;
                        phase_step = PH_STR;
                    end
                    else begin
                        if (held == 3'd1) hold_step[15:8] = in_byte;
                        else hold_step[7:0] = in_byte;
                        rem_step = rem_reg - 2'd1;
                    end
                end
            end
            default:
                phase_step = phase_reg;
        endcase
        if (err) phase_step = PH_SILENT;
    end

    // The final byte of a buffer returns everything to the reset state.
    always_comb
    begin
        if (in_last) begin
            phase_next   = PH_IDLE;
            hold_next    = '0;
            rem_next     = '0;
            accum_next   = '0;
            hex_cnt_next = '0;
            high_next    = '0;
            pos_next     = '0;
        end
        else begin
            phase_next   = phase_step;
            hold_next    = hold_step;
            rem_next     = rem_step;
            accum_next   = accum_step;
            hex_cnt_next = hex_cnt_step;
            high_next    = high_step;
            pos_next     = nxt;
        end
    end

    // Results for the byte in hand.
    always_comb
    begin
        res_valid    = 1'b0;
        grp.data     = '0;
        grp.last_idx = 2'd0;
        grp.status   = ST_DATA;
        grp.offset   = '0;
        case (phase_reg)
            PH_STR:
            begin
                if (in_byte == CH_QUOTE) begin
                    res_valid  = 1'b1;
                    grp.status = ST_DONE;
                end
                else if (in_byte != CH_BSL && in_byte >= 8'h20 && in_byte < 8'h80) begin
                    res_valid   = 1'b1;
                    grp.data[0] = in_byte;
                end
            end
            PH_ESC:
            begin
                res_valid = 1'b1;
                case (in_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: grp.data[0] = in_byte;
                    CH_B:    grp.data[0] = 8'h08;
                    CH_F:    grp.data[0] = 8'h0C;
                    CH_N:    grp.data[0] = 8'h0A;
                    CH_R:    grp.data[0] = 8'h0D;
                    CH_T:    grp.data[0] = 8'h09;
                    default: res_valid   = 1'b0;
                endcase
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                if (!hex_bad && hex_cnt_reg == 2'd3 &&
                    ((phase_reg == PH_HEX_HI && !is_hi && !is_lo) ||
                     (phase_reg == PH_HEX_LO && is_lo))) begin
                    res_valid    = 1'b1;
                    grp.data     = enc.data;
                    grp.last_idx = enc.last_idx;
                end
            end
            PH_UTF8:
            begin
                if (cont_ok && rem_reg <= 2'd1) begin
                    res_valid    = 1'b1;
                    grp.data[0]  = lead;
                    grp.data[1]  = (held >= 3'd2) ? hold_reg[15:8] : in_byte;
                    grp.data[2]  = (held >= 3'd3) ? hold_reg[7:0] : in_byte;
                    grp.data[3]  = in_byte;
                    grp.last_idx = held[1:0];
                end
            end
            default:
                res_valid = 1'b0;
        endcase

        if (err) begin
            res_valid    = 1'b1;
            grp.data     = '0;
            grp.last_idx = 2'd0;
            grp.status   = est;
            grp.offset   = OFF_W'(eoff);
        end
        else if (in_last && phase_step != PH_IDLE && phase_step != PH_SILENT) begin
            // Buffer ended inside the string: one error replaces any data.
            res_valid    = 1'b1;
            grp.data     = '0;
            grp.last_idx = 2'd0;
            if (phase_step == PH_UTF8) begin
                grp.status = ST_UTF8;
                grp.offset = OFF_W'((nxt >= pos_t'(held_end)) ? nxt - pos_t'(held_end) : '0);
            end
            else if (phase_step == PH_STR || phase_step == PH_ESC) begin
                grp.status = ST_UNTERM;
                grp.offset = OFF_W'(nxt);
            end
            else begin
                grp.status = ST_ESC;
                grp.offset = OFF_W'(nxt);
            end
        end
    end

    assign grp_valid = take && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            hold_reg    <= '0;
            rem_reg     <= '0;
            accum_reg   <= '0;
            hex_cnt_reg <= '0;
            high_reg    <= '0;
            pos_reg     <= '0;
        end
        else if (take) begin
            phase_reg   <= phase_next;
            hold_reg    <= hold_next;
            rem_reg     <= rem_next;
            accum_reg   <= accum_next;
            hex_cnt_reg <= hex_cnt_next;
            high_reg    <= high_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// File: rtl/core/jsu_group_fifo.sv
// Two-entry queue of result groups with a serialiser that sends one beat
// per result of the group at its head. Depends on jsu_pkg.
module jsu_group_fifo
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  group_t           push_grp,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output status_t          out_status,
    output logic             out_last,
    output logic [OFF_W-1:0] out_offset
);

    group_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] idx_reg, idx_next;
    group_t     head;
    logic       beat;
    logic       pop;

    assign head       = mem[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);
    assign out_valid  = (count_reg != 2'd0);
    assign out_byte   = head.data[idx_reg];
    assign out_status = head.status;
    assign out_last   = (idx_reg == head.last_idx);
    assign out_offset = head.offset;

    assign beat = out_valid && out_ready;
    assign pop  = beat && out_last;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        if (pop) idx_next = 2'd0;
        else if (beat) idx_next = idx_reg + 2'd1;
        else idx_next = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// File: rtl/core/jsu_checker.sv
// Port-level checks on the unescaper's result stream, bound to the top level.
// Depends on jsu_pkg for the status codes.
module jsu_checker
    import jsu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result beat keeps its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Completion and error results stand alone, so each ends its run.
    a_single_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_DATA |-> m_tlast)
        else $error("non-data result without tlast");

    // Data beats carry no error offset.
    a_data_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_DATA |-> m_tdata[23:8] == 16'h0000)
        else $error("data beat with non-zero offset");

    // A completion beat carries neither a byte nor an offset.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_DONE |-> m_tdata == 24'h000000)
        else $error("completion beat with non-zero payload");

endmodule

bind json_string_unescaper_core jsu_checker u_checker (.*);

// File: verif/tb_top.sv
// Self-checking bench for json_string_unescaper_core: drives string literals byte by
// byte and compares every output beat with a cycle-free decoder held in the bench.
// Depends on jsu_pkg and the RTL of the core only.
module tb_top
    import jsu_pkg::*;
();

    localparam int LIMIT_CYCLES = 40000;
    localparam int RAND_ITEMS   = 12;

    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct {
        logic [7:0]       data;
        status_t          status;
        logic             last;
        logic [OFF_W-1:0] offset;
    } beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    json_string_unescaper_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    beat_t      expected_beats[$];
    beat_t      step_beats[$];
    logic [7:0] text_q[$];
    int         fail_cnt   = 0;
    int         cycle_cnt  = 0;
    int         stall_left = 0;
    bit         idle_on    = 1'b1;

    logic [7:0]  esc_letters[8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    logic [20:0] corner_cps[9]  = '{21'h80, 21'h7FF, 21'h800, 21'hFFF, 21'hD7FF, 21'hE000,
                                    21'h10000, 21'h3FFFF, 21'h10FFFF};

    // Decoder state kept by the bench.
    phase_t      dec_phase;
    logic [23:0] dec_hold;
    logic [1:0]  dec_rem;
    logic [15:0] dec_code;
    logic [1:0]  dec_hex;
    logic [9:0]  dec_high;
    pos_t        dec_pos;

    function automatic void decoder_reset();
        dec_phase = PH_IDLE;
        dec_hold  = '0;
        dec_rem   = '0;
        dec_code  = '0;
        dec_hex   = '0;
        dec_high  = '0;
        dec_pos   = '0;
    endfunction

    function automatic int utf8_count(input logic [20:0] cp);
        if (cp <= 21'h7F) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input int k);
        int          n;
        logic [20:0] s;
        n = utf8_count(cp);
        s = cp >> (6 * (n - 1 - k));
        if (n == 1) return cp[7:0];
        if (k != 0) return {2'b10, s[5:0]};
        case (n)
            2:       return {3'b110, s[4:0]};
            3:       return {4'b1110, s[3:0]};
            default: return {5'b11110, s[2:0]};
        endcase
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        if (b >= 8'hC2 && b <= 8'hDF) return 3'd2;
        if (b >= 8'hE0 && b <= 8'hEF) return 3'd3;
        if (b >= 8'hF0 && b <= 8'hF4) return 3'd4;
        return 3'd0;
    endfunction

    // Bit 4 set marks a byte that is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (b >= CH_DIGIT0 && b <= 8'h39) return 5'(b - CH_DIGIT0);
        if (b >= CH_LOWER_A && b <= 8'h66) return 5'(b - CH_LOWER_A + 8'd10);
        if (b >= CH_UPPER_A && b <= 8'h46) return 5'(b - CH_UPPER_A + 8'd10);
        return 5'h10;
    endfunction

    function automatic logic [2:0] held_bytes();
        logic [2:0] len;
        len = seq_len(dec_hold[23:16]);
        return (len > {1'b0, dec_rem}) ? 3'(len - {1'b0, dec_rem}) : 3'd1;
    endfunction

    function automatic void add_result(input logic [7:0] d, input status_t st,
                                       input logic [OFF_W-1:0] off);
        beat_t r;
        if (step_beats.size() < 4)
        begin
            r.data   = d;
            r.status = st;
            r.last   = 1'b0;
            r.offset = off;
            step_beats.insert(step_beats.size(), r);
        end
    endfunction

    function automatic void add_code_point(input logic [20:0] cp);
        for (int k = 0; k < utf8_count(cp); k++)
            add_result(utf8_byte(cp, k), ST_DATA, '0);
    endfunction

    // Works out the beats that one accepted input byte gives, in order.
    function automatic void decode_byte(input logic [7:0] b, input logic is_last);
        pos_t             cur;
        pos_t             nxt;
        logic             err;
        status_t          est;
        logic [OFF_W-1:0] eoff;
        logic [4:0]       h;
        logic [2:0]       held;
        logic [7:0]       lead;
        logic [7:0]       lo;
        logic [7:0]       hi;
        cur  = dec_pos;
        nxt  = (cur == POS_MAX) ? POS_MAX : cur + 1'b1;
        err  = 1'b0;
        est  = ST_DATA;
        eoff = '0;
        step_beats.delete();
        case (dec_phase)
            PH_IDLE:
            begin
                if (b == CH_QUOTE) dec_phase = PH_STR;
                else
                begin
                    err = 1'b1; est = ST_UNTERM; eoff = '0;
                end
            end
            PH_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    add_result(8'h00, ST_DONE, '0);
                    dec_phase = PH_SILENT;
                end
                else if (b == CH_BSL) dec_phase = PH_ESC;
                else if (b < 8'h20)
                begin
                    err = 1'b1; est = ST_UNTERM; eoff = cur;
                end
                else if (b < 8'h80) add_result(b, ST_DATA, '0);
                else if (seq_len(b) == 3'd0)
                begin
                    err = 1'b1; est = ST_UTF8; eoff = cur;
                end
                else
                begin
                    dec_hold  = {b, 16'h0000};
                    dec_rem   = 2'(seq_len(b) - 3'd1);
                    dec_phase = PH_UTF8;
                end
            end
            PH_ESC:
            begin
                dec_phase = PH_STR;
                case (b)
                    CH_QUOTE, CH_BSL, CH_SLASH: add_result(b, ST_DATA, '0);
                    CH_B: add_result(8'h08, ST_DATA, '0);
                    CH_F: add_result(8'h0C, ST_DATA, '0);
                    CH_N: add_result(8'h0A, ST_DATA, '0);
                    CH_R: add_result(8'h0D, ST_DATA, '0);
                    CH_T: add_result(8'h09, ST_DATA, '0);
                    CH_U:
                    begin
                        dec_phase = PH_HEX_HI;
                        dec_hex   = '0;
                        dec_code  = '0;
                    end
                    default:
                    begin
                        err = 1'b1; est = ST_ESC; eoff = nxt;
                    end
                endcase
            end
            PH_HEX_HI, PH_HEX_LO:
            begin
                h = hex_digit(b);
                if (h[4])
                begin
                    err = 1'b1; est = ST_ESC; eoff = cur;
                end
                else
                begin
                    dec_code = {dec_code[11:0], h[3:0]};
                    if (dec_hex < 2'd3) dec_hex = dec_hex + 2'd1;
                    else
                    begin
                        dec_hex = '0;
                        if (dec_phase == PH_HEX_HI)
                        begin
                            if (dec_code >= HI_SURR_MIN && dec_code <= HI_SURR_MAX)
                            begin
                                dec_high  = 10'(dec_code - HI_SURR_MIN);
                                dec_phase = PH_WANT_BSL;
                            end
                            else if (dec_code >= LO_SURR_MIN && dec_code <= LO_SURR_MAX)
                            begin
                                err = 1'b1; est = ST_ESC; eoff = nxt;
                            end
                            else
                            begin
                                add_code_point(21'(dec_code));
                                dec_phase = PH_STR;
                            end
                        end
                        else if (dec_code >= LO_SURR_MIN && dec_code <= LO_SURR_MAX)
                        begin
                            add_code_point(SUPP_BASE + 21'({dec_high, dec_code[9:0]}));
                            dec_phase = PH_STR;
                        end
                        else
                        begin
                            err = 1'b1; est = ST_ESC; eoff = nxt;
                        end
                    end
                end
            end
            PH_WANT_BSL:
            begin
                if (b == CH_BSL) dec_phase = PH_WANT_U;
                else
                begin
                    err = 1'b1; est = ST_ESC; eoff = cur;
                end
            end
            PH_WANT_U:
            begin
                if (b == CH_U)
                begin
                    dec_phase = PH_HEX_LO;
                    dec_hex   = '0;
                    dec_code  = '0;
                end
                else
                begin
                    err = 1'b1; est = ST_ESC; eoff = cur;
                end
            end
            PH_UTF8:
            begin
                lead = dec_hold[23:16];
                held = held_bytes();
                lo   = 8'h80;
                hi   = 8'hBF;
                // The second byte of some leads has a narrower range.
                if (held == 3'd1)
                begin
                    if (lead == 8'hE0) lo = 8'hA0;
                    else if (lead == 8'hED) hi = 8'h9F;
                    else if (lead == 8'hF0) lo = 8'h90;
                    else if (lead == 8'hF4) hi = 8'h8F;
                end
                if (b < lo || b > hi)
                begin
                    err  = 1'b1;
                    est  = ST_UTF8;
                    eoff = (cur >= pos_t'(held)) ? cur - pos_t'(held) : '0;
                end
                else if (dec_rem <= 2'd1)
                begin
                    add_result(lead, ST_DATA, '0);
                    if (held >= 3'd2) add_result(dec_hold[15:8], ST_DATA, '0);
                    if (held >= 3'd3) add_result(dec_hold[7:0], ST_DATA, '0);
                    add_result(b, ST_DATA, '0);
                    dec_rem   = '0;
                    dec_phase = PH_STR;
                end
                else
                begin
                    if (held == 3'd1) dec_hold[15:8] = b;
                    else dec_hold[7:0] = b;
                    dec_rem = dec_rem - 2'd1;
                end
            end
            default: ;
        endcase

        if (err)
        begin
            step_beats.delete();
            add_result(8'h00, est, eoff);
            dec_phase = PH_SILENT;
        end
        dec_pos = nxt;

        // End of buffer inside an open string replaces any data with one error.
        if (is_last)
        begin
            if (!err && dec_phase >= PH_STR && dec_phase <= PH_UTF8)
            begin
                step_beats.delete();
                if (dec_phase == PH_UTF8)
                begin
                    held = held_bytes();
                    add_result(8'h00, ST_UTF8,
                               (nxt >= pos_t'(held)) ? nxt - pos_t'(held) : '0);
                end
                else if (dec_phase == PH_STR || dec_phase == PH_ESC)
                    add_result(8'h00, ST_UNTERM, nxt);
                else
                    add_result(8'h00, ST_ESC, nxt);
            end
            decoder_reset();
        end

        if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_cnt++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : check_beat
        beat_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected beat, expected none, actual data 0x%0h status %0d",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                w = expected_beats.pop_front();
                if (m_tdata[7:0] !== w.data) note_mismatch("out_byte", w.data, m_tdata[7:0]);
                if (m_tuser !== w.status) note_mismatch("status", w.status, m_tuser);
                if (m_tlast !== w.last) note_mismatch("last_of_run", w.last, m_tlast);
                if (m_tdata[23:8] !== w.offset)
                    note_mismatch("error_offset", w.offset, m_tdata[23:8]);
            end
        end
    end

    // Receiver stalls in short bursts.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("** json_string_unescaper_core: FAILED **");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [7:0] b, input logic is_last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        decode_byte(b, is_last);
        @(negedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_esc(input logic [7:0] letter);
        put_byte(CH_BSL);
        put_byte(letter);
    endfunction

    function automatic void put_uesc(input logic [15:0] v, input bit upper);
        logic [3:0] nib;
        put_esc(CH_U);
        for (int i = 3; i >= 0; i--)
        begin
            nib = v[4*i +: 4];
            if (nib < 4'd10) put_byte(CH_DIGIT0 + nib);
            else put_byte((upper ? CH_UPPER_A : CH_LOWER_A) + nib - 8'd10);
        end
    endfunction

    function automatic void put_raw(input logic [20:0] cp);
        for (int k = 0; k < utf8_count(cp); k++) put_byte(utf8_byte(cp, k));
    endfunction

    task automatic test_escapes();
        put_byte(CH_QUOTE);
        foreach (esc_letters[i]) put_esc(esc_letters[i]);
        put_uesc(16'h00E9, 1'b0);
        put_uesc(16'h20AC, 1'b1);
        put_uesc(16'hD800, 1'b1);
        put_uesc(16'hDC00, 1'b0);
        put_byte(CH_QUOTE);
        send_buffer();
    endtask

    task automatic test_raw_utf8();
        put_byte(CH_QUOTE);
        put_byte(8'h7F);
        put_raw(21'h80);
        put_raw(21'hD7FF);
        put_raw(21'hE000);
        put_raw(21'h10000);
        put_raw(21'h10FFFF);
        put_byte(CH_QUOTE);
        send_buffer();
    endtask

    task automatic test_framing_errors();
        put_byte(8'h78);                                send_buffer();
        put_byte(8'hFF); put_byte(CH_QUOTE);            send_buffer();
        put_byte(CH_QUOTE);                             send_buffer();
        put_byte(CH_QUOTE); put_byte(8'h1F);            send_buffer();
        put_str("\"a\"x\"");                            send_buffer();
        put_str("\"\\");                                send_buffer();
    endtask

    task automatic test_escape_errors();
        put_str("\"\\q");            send_buffer();
        put_str("\"\\uDC00\"");      send_buffer();
        put_str("\"\\uD800x");       send_buffer();
        put_str("\"\\uD800\\u0041"); send_buffer();
        put_str("\"\\u0G");          send_buffer();
    endtask

    task automatic test_utf8_errors();
        put_byte(CH_QUOTE); put_byte(8'h80);                         send_buffer();
        put_byte(CH_QUOTE); put_byte(8'hE0); put_byte(8'h9F);        send_buffer();
        put_byte(CH_QUOTE); put_byte(8'hED); put_byte(8'hA0);        send_buffer();
        put_byte(CH_QUOTE); put_byte(8'hF0); put_byte(8'h8F);        send_buffer();
        put_byte(CH_QUOTE); put_byte(8'hF4); put_byte(8'h90);        send_buffer();
        put_byte(CH_QUOTE); put_byte(8'hC2); put_byte(8'h41);        send_buffer();
        put_byte(CH_QUOTE); put_byte(8'hE1); put_byte(8'h80);        send_buffer();
    endtask

    function automatic void put_segment();
        logic [7:0]  c;
        logic [15:0] v;
        logic [20:0] cp;
        case ($urandom_range(0, 5))
            0:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    if (c == CH_QUOTE || c == CH_BSL) c = 8'h61;
                    put_byte(c);
                end
            end
            1: put_esc(esc_letters[3'($urandom_range(0, 7))]);
            2:
            begin
                v = 16'($urandom_range(0, 16'hFFFF));
                if (v >= HI_SURR_MIN && v <= LO_SURR_MAX) v = v ^ 16'h4000;
                put_uesc(v, 1'($urandom_range(0, 1)));
            end
            3:
            begin
                put_uesc(HI_SURR_MIN + 16'($urandom_range(0, 10'h3FF)),
                         1'($urandom_range(0, 1)));
                put_uesc(LO_SURR_MIN + 16'($urandom_range(0, 10'h3FF)),
                         1'($urandom_range(0, 1)));
            end
            4:
            begin
                case ($urandom_range(0, 2))
                    0: cp = 21'($urandom_range(21'h80, 21'h7FF));
                    1:
                    begin
                        cp = 21'($urandom_range(21'h800, 21'hFFFF));
                        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h4000;
                    end
                    default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                endcase
                put_raw(cp);
            end
            default: put_raw(corner_cps[4'($urandom_range(0, 8))]);
        endcase
    endfunction

    // Mostly well-formed strings; the rest is corrupted, cut short or plain noise.
    function automatic void build_random_buffer();
        int kind;
        int mark;
        int seg_len;
        kind = $urandom_range(0, 9);
        put_byte(CH_QUOTE);
        repeat ($urandom_range(1, 5)) put_segment();
        if (kind < 6)
        begin
            put_byte(CH_QUOTE);
            repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 8)
        begin
            put_segment();
            text_q[text_q.size() - 1] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) put_segment();
            put_byte(CH_QUOTE);
        end
        else if (kind == 8)
        begin
            mark = text_q.size();
            put_segment();
            seg_len = text_q.size() - mark;
            if (seg_len > 1)
                repeat ($urandom_range(1, seg_len - 1)) void'(text_q.pop_back());
        end
        else
        begin
            text_q.delete();
            if ($urandom_range(0, 1)) put_byte(CH_QUOTE);
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // The closing buffer runs with no idling on either side.
    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            build_random_buffer();
            sent += text_q.size();
            send_buffer();
        end
        idle_on = 1'b0;
        build_random_buffer();
        send_buffer();
    endtask

    initial
    begin
        decoder_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_escapes();
        test_raw_utf8();
        drain_results();
        test_framing_errors();
        test_escape_errors();
        test_utf8_errors();
        test_random();

        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
        repeat (16) @(negedge clk);
        if (fail_cnt == 0)
            $display("** json_string_unescaper_core: PASSED **");
        else
            $display("** json_string_unescaper_core: FAILED **");
        $finish;
    end

endmodule
